// File: rtl/fird_pkg.sv
// Shared definitions for the decimating FIR filter: widths, codes, queue entry
// and status types, and the helpers that clamp the configuration registers.
// No dependencies.
package fird_pkg;

   // Storage and arithmetic widths.
   localparam int MAX_TAPS    = 1024;
   localparam int ADDR_W      = $clog2(MAX_TAPS);
   localparam int TAPS_W      = ADDR_W + 1;
   localparam int SAMPLE_BITS = 16;
   localparam int COEF_BITS   = 16;
   localparam int COEF_FRAC   = 15;
   localparam int PROD_W      = SAMPLE_BITS + COEF_BITS;
   localparam int ACC_W       = PROD_W + ADDR_W;

   // Decimation ratio limits.
   localparam int RATIO_W   = 5;
   localparam int RATIO_MAX = 16;
   localparam int PHASE_W   = 4;

   // Configuration port.
   localparam int CSR_IDX_W  = 1;
   localparam int CSR_DATA_W = TAPS_W;
   localparam logic [CSR_IDX_W-1:0] CSR_RATIO = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_TAPS  = 1'b1;
   localparam logic [RATIO_W-1:0]   RATIO_RESET = RATIO_W'(5);
   localparam logic [TAPS_W-1:0]    TAPS_RESET  = TAPS_W'(565);

   // Request operation codes.
   localparam logic OP_SAMPLE = 1'b0;
   localparam logic OP_LOAD   = 1'b1;

   // Queue between the front and back ends.
   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   // Rounding and saturation constants at accumulator width.
   localparam logic signed [ACC_W-1:0] ROUND_HALF = ACC_W'(2 ** (COEF_FRAC - 1));
   localparam logic signed [ACC_W-1:0] SAT_MAX    = ACC_W'(2 ** (SAMPLE_BITS - 1) - 1);
   localparam logic signed [ACC_W-1:0] SAT_MIN    = -ACC_W'(2 ** (SAMPLE_BITS - 1));

   // One classified request as passed to the back end.
   typedef struct packed {
      logic                          op;
      logic [ADDR_W-1:0]             addr;
      logic signed [SAMPLE_BITS-1:0] value;
      logic                          fire;
      logic [ADDR_W-1:0]             start_pos;
   } q_entry_type;

   // Back-end status seen by the rest of the block.
   typedef struct packed {
      logic clearing;
      logic busy;
   } back_status_type;

   // Ratio of zero acts as one; above the maximum acts as the maximum.
   function automatic logic [RATIO_W-1:0] eff_ratio(input logic [RATIO_W-1:0] r);
      logic [RATIO_W-1:0] res;
      res = r;
      if (r == '0) begin
         res = RATIO_W'(1);
      end else if (r > RATIO_W'(RATIO_MAX)) begin
         res = RATIO_W'(RATIO_MAX);
      end
      return res;
   endfunction

   // Tap count of zero acts as one; above the store depth acts as the depth.
   function automatic logic [TAPS_W-1:0] eff_taps(input logic [TAPS_W-1:0] t);
      logic [TAPS_W-1:0] res;
      res = t;
      if (t == '0) begin
         res = TAPS_W'(1);
      end else if (t > TAPS_W'(MAX_TAPS)) begin
         res = TAPS_W'(MAX_TAPS);
      end
      return res;
   endfunction

endpackage

// File: rtl/fir_decimator.sv
// Decimating FIR filter for 16-bit audio samples.
//
// Requests arrive on the req_ channel (valid/stall). A request with operation
// zero is an audio sample, written into a circular sample ring; a request
// with operation one loads one coefficient at coef_index. Every ratio samples
// the block delivers one result on the rsp_ channel: the dot product of the
// coefficients with the stored samples (coefficient zero meets the oldest
// sample), rounded from Q1.15 and saturated, with clipped set on saturation.
// Coefficient loads and the other samples give no result.
// The csr_ channel writes ratio (index 0) and tap_count (index 1); it is
// always ready, and writes belong only while the block is idle.
// Throughput: a sample that completes an output occupies the single shared
// multiply-accumulate unit for its whole tap loop, one tap per cycle
// through the sample and coefficient memory read ports; other requests are
// written straight from idle. A two-entry queue and the output register let
// requests be taken while a result waits, and a stalled result simply holds
// the loop's output. After reset both stores are cleared to zero while
// req_stall stays high; the registers return to ratio 5 and tap_count 565.
module fir_decimator
   import fird_pkg::*;
(
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic                          req_operation,
   input  logic [ADDR_W-1:0]             req_coef_index,
   input  logic signed [SAMPLE_BITS-1:0] req_value,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic signed [SAMPLE_BITS-1:0] rsp_filtered_sample,
   output logic                          rsp_clipped,
   input  logic                          csr_valid,
   output logic                          csr_ready,
   input  logic [CSR_IDX_W-1:0]          csr_index,
   input  logic [CSR_DATA_W-1:0]         csr_wdata
);

   logic [RATIO_W-1:0] ratio_ff, ratio_in;
   logic [TAPS_W-1:0]  taps_ff, taps_in;
   logic [RATIO_W-1:0] ratio_eff;
   logic [TAPS_W-1:0]  taps_eff;

   logic            push, pop, queue_full, queue_empty;
   q_entry_type     push_entry, pop_entry;
   back_status_type back_status;

   // Configuration registers.
   assign csr_ready = 1'b1;

   always_comb begin
      ratio_in = ratio_ff;
      taps_in  = taps_ff;
      if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_RATIO: ratio_in = csr_wdata[RATIO_W-1:0];
            CSR_TAPS:  taps_in  = csr_wdata;
            default:   ratio_in = ratio_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ratio_ff <= RATIO_RESET;
         taps_ff  <= TAPS_RESET;
      end else begin
         ratio_ff <= ratio_in;
         taps_ff  <= taps_in;
      end
   end

   assign ratio_eff = eff_ratio(ratio_ff);
   assign taps_eff  = eff_taps(taps_ff);

   // Front end, queue and back end.
   fird_front u_front (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_operation  (req_operation),
      .req_coef_index (req_coef_index),
      .req_value      (req_value),
      .ratio_eff      (ratio_eff),
      .taps_eff       (taps_eff),
      .queue_full     (queue_full),
      .back_status    (back_status),
      .push           (push),
      .entry          (push_entry)
   );

   fird_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_entry (push_entry),
      .pop        (pop),
      .pop_entry  (pop_entry),
      .full       (queue_full),
      .empty      (queue_empty)
   );

   fird_back u_back (
      .clock               (clock),
      .reset               (reset),
      .taps_eff            (taps_eff),
      .queue_empty         (queue_empty),
      .queue_entry         (pop_entry),
      .pop                 (pop),
      .status              (back_status),
      .rsp_valid           (rsp_valid),
      .rsp_stall           (rsp_stall),
      .rsp_filtered_sample (rsp_filtered_sample),
      .rsp_clipped         (rsp_clipped)
   );

`ifndef SYNTHESIS
   // No result can appear while the stores are still being cleared.
   a_no_rsp_in_clear: assert property (@(posedge clock) disable iff (reset)
      back_status.clearing |-> !rsp_valid)
      else $error("result presented during clearing pass");

   // A clipped result sits exactly at one of the saturation limits.
   a_clip_at_limit: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_clipped) |->
         (rsp_filtered_sample == 16'sh7fff || rsp_filtered_sample == 16'sh8000))
      else $error("clipped result not at a saturation limit");

   // A new result only follows work in the back end.
   a_rsp_from_loop: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(back_status.busy))
      else $error("result appeared without a completed tap loop");

   // The queue never pops while empty.
   a_pop_nonempty: assert property (@(posedge clock) disable iff (reset)
      pop |-> !queue_empty)
      else $error("queue popped while empty");
`endif

endmodule

// File: rtl/fird_front.sv
// Front end of the decimating FIR filter: accepts requests, tracks the ring
// write position and the decimation phase, and pushes classified entries.
// Depends on fird_pkg.
module fird_front
   import fird_pkg::*;
(
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic                          req_operation,
   input  logic [ADDR_W-1:0]             req_coef_index,
   input  logic signed [SAMPLE_BITS-1:0] req_value,
   input  logic [RATIO_W-1:0]            ratio_eff,
   input  logic [TAPS_W-1:0]             taps_eff,
   input  logic                          queue_full,
   input  back_status_type               back_status,
   output logic                          push,
   output q_entry_type                   entry
);

   logic [ADDR_W-1:0]  wp_ff, wp_in;
   logic [PHASE_W-1:0] phase_ff, phase_in;
   logic [ADDR_W-1:0]  pos;
   logic [TAPS_W-1:0]  pos_inc;
   logic [ADDR_W-1:0]  next_pos;
   logic [RATIO_W-1:0] phase_inc;
   logic               due;

   // Requests wait while the queue is full or the stores are being cleared.
   assign req_stall = queue_full | back_status.clearing;
   assign push      = req_valid & ~req_stall;

   // Work out where a sample lands and whether it completes an output.
   always_comb begin
      pos       = (TAPS_W'(wp_ff) < taps_eff) ? wp_ff : '0;
      pos_inc   = TAPS_W'(pos) + TAPS_W'(1);
      next_pos  = (pos_inc >= taps_eff) ? '0 : pos_inc[ADDR_W-1:0];
      phase_inc = RATIO_W'(phase_ff) + RATIO_W'(1);
      due       = (phase_inc >= ratio_eff);

      entry.op        = req_operation;
      entry.addr      = (req_operation == OP_LOAD) ? req_coef_index : pos;
      entry.value     = req_value;
      entry.fire      = (req_operation == OP_SAMPLE) & due;
      entry.start_pos = next_pos;

      wp_in    = wp_ff;
      phase_in = phase_ff;
      if (push && (req_operation == OP_SAMPLE)) begin
         wp_in    = next_pos;
         phase_in = due ? '0 : phase_inc[PHASE_W-1:0];
      end
   end

   // Position and phase registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff    <= '0;
         phase_ff <= '0;
      end else begin
         wp_ff    <= wp_in;
         phase_ff <= phase_in;
      end
   end

endmodule

// File: rtl/fird_queue.sv
// Short first-in first-out queue that decouples the front and back ends.
// Depends on fird_pkg.
module fird_queue
   import fird_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        push,
   input  q_entry_type push_entry,
   input  logic        pop,
   output q_entry_type pop_entry,
   output logic        full,
   output logic        empty
);

   q_entry_type       slot_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0] count_ff, count_in;

   assign full      = (count_ff == QCNT_W'(QUEUE_DEPTH));
   assign empty     = (count_ff == '0);
   assign pop_entry = slot_ff[rd_ptr_ff];

   // Pointer and occupancy update.
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + QPTR_W'(1);
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + QPTR_W'(1);
      end
      if (push && !pop) begin
         count_in = count_ff + QCNT_W'(1);
      end else if (pop && !push) begin
         count_in = count_ff - QCNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Entry storage; no reset needed for payload.
   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_entry;
      end
   end

endmodule

// File: rtl/fird_back.sv
// Back end of the decimating FIR filter: holds the sample ring and the
// coefficient store, runs the shared multiply-accumulate loop, then rounds,
// saturates and registers each output. Depends on fird_pkg.
module fird_back
   import fird_pkg::*;
(
   input  logic                          clock,
   input  logic                          reset,
   input  logic [TAPS_W-1:0]             taps_eff,
   input  logic                          queue_empty,
   input  q_entry_type                   queue_entry,
   output logic                          pop,
   output back_status_type               status,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic signed [SAMPLE_BITS-1:0] rsp_filtered_sample,
   output logic                          rsp_clipped
);

   typedef enum logic [4:0] {
      ST_CLEAR  = 5'b00001,
      ST_IDLE   = 5'b00010,
      ST_MAC    = 5'b00100,
      ST_DRAIN  = 5'b01000,
      ST_FINISH = 5'b10000
   } state_type;

   state_type state_ff, state_in;

   logic signed [SAMPLE_BITS-1:0] sample_mem [MAX_TAPS];
   logic signed [COEF_BITS-1:0]   coef_mem   [MAX_TAPS];

   logic [ADDR_W-1:0] clr_addr_ff, clr_addr_in;
   logic [ADDR_W-1:0] tap_ff, tap_in;
   logic [ADDR_W-1:0] idx_ff, idx_in;
   logic [TAPS_W-1:0] idx_inc;
   logic              rd_vld_ff, prod_vld_ff;
   logic signed [SAMPLE_BITS-1:0] samp_rd_ff;
   logic signed [COEF_BITS-1:0]   coef_rd_ff;
   logic signed [PROD_W-1:0]      prod_ff;
   logic signed [ACC_W-1:0]       acc_ff, acc_in;
   logic                          acc_clear;

   logic                          samp_we, coef_we;
   logic [ADDR_W-1:0]             waddr;
   logic signed [SAMPLE_BITS-1:0] wdata;

   logic signed [ACC_W-1:0]       rounded, shifted;
   logic signed [SAMPLE_BITS-1:0] sat_value;
   logic                          sat_clip;
   logic                          rsp_load;
   logic                          rsp_valid_ff, rsp_valid_in;
   logic signed [SAMPLE_BITS-1:0] rsp_sample_ff;
   logic                          rsp_clip_ff;

   assign status.clearing     = (state_ff == ST_CLEAR);
   assign status.busy         = (state_ff != ST_IDLE);
   assign rsp_valid           = rsp_valid_ff;
   assign rsp_filtered_sample = rsp_sample_ff;
   assign rsp_clipped         = rsp_clip_ff;

   // Round half up, drop the fraction bits and saturate.
   always_comb begin
      rounded   = acc_ff + ROUND_HALF;
      shifted   = rounded >>> COEF_FRAC;
      sat_clip  = 1'b0;
      sat_value = shifted[SAMPLE_BITS-1:0];
      if (shifted > SAT_MAX) begin
         sat_value = SAT_MAX[SAMPLE_BITS-1:0];
         sat_clip  = 1'b1;
      end else if (shifted < SAT_MIN) begin
         sat_value = SAT_MIN[SAMPLE_BITS-1:0];
         sat_clip  = 1'b1;
      end
   end

   // Sequencer: clearing pass, request execution and the tap loop.
   always_comb begin
      state_in    = state_ff;
      clr_addr_in = clr_addr_ff;
      tap_in      = tap_ff;
      idx_in      = idx_ff;
      idx_inc     = TAPS_W'(idx_ff) + TAPS_W'(1);
      pop         = 1'b0;
      acc_clear   = 1'b0;
      samp_we     = 1'b0;
      coef_we     = 1'b0;
      waddr       = queue_entry.addr;
      wdata       = queue_entry.value;
      rsp_load    = 1'b0;
      case (state_ff)
         ST_CLEAR: begin
            samp_we     = 1'b1;
            coef_we     = 1'b1;
            waddr       = clr_addr_ff;
            wdata       = '0;
            clr_addr_in = clr_addr_ff + ADDR_W'(1);
            if (clr_addr_ff == ADDR_W'(MAX_TAPS - 1)) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (!queue_empty) begin
               pop     = 1'b1;
               samp_we = (queue_entry.op == OP_SAMPLE);
               coef_we = (queue_entry.op == OP_LOAD);
               if (queue_entry.fire) begin
                  acc_clear = 1'b1;
                  tap_in    = '0;
                  idx_in    = queue_entry.start_pos;
                  state_in  = ST_MAC;
               end
            end
         end
         ST_MAC: begin
            tap_in = tap_ff + ADDR_W'(1);
            idx_in = (idx_inc >= taps_eff) ? '0 : idx_inc[ADDR_W-1:0];
            if (TAPS_W'(tap_ff) == taps_eff - TAPS_W'(1)) begin
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: begin
            if (!rd_vld_ff && !prod_vld_ff) begin
               state_in = ST_FINISH;
            end
         end
         ST_FINISH: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_load = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_CLEAR;
         end
      endcase
   end

   // Output register takes a new result as the old one leaves; accumulator clears or adds each product.
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (rsp_load) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
      acc_in = acc_ff;
      if (acc_clear) begin
         acc_in = '0;
      end else if (prod_vld_ff) begin
         acc_in = acc_ff + ACC_W'(prod_ff);
      end
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clr_addr_ff  <= '0;
         rd_vld_ff    <= 1'b0;
         prod_vld_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_addr_ff  <= clr_addr_in;
         rd_vld_ff    <= (state_ff == ST_MAC);
         prod_vld_ff  <= rd_vld_ff;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Datapath registers: loop indices, product, accumulator and output.
   always_ff @(posedge clock) begin
      tap_ff  <= tap_in;
      idx_ff  <= idx_in;
      prod_ff <= samp_rd_ff * coef_rd_ff;
      acc_ff  <= acc_in;
      if (rsp_load) begin
         rsp_sample_ff <= sat_value;
         rsp_clip_ff   <= sat_clip;
      end
   end

   // Sample ring: one write port, one registered read port.
   always_ff @(posedge clock) begin
      if (samp_we) begin
         sample_mem[waddr] <= wdata;
      end
      samp_rd_ff <= sample_mem[idx_ff];
   end

   // Coefficient store: one write port, one registered read port.
   always_ff @(posedge clock) begin
      if (coef_we) begin
         coef_mem[waddr] <= wdata;
      end
      coef_rd_ff <= coef_mem[tap_ff];
   end

endmodule

// File: tb/fir_decimator_tb.sv
// Self-checking testbench for the decimating FIR filter: drives requests and
// configuration writes and checks every decimated output against its own
// bit-exact prediction of the filter. Depends on fird_pkg and fir_decimator.
module fir_decimator_tb
   import fird_pkg::*;
;
   timeunit 1ns;
   timeprecision 1ps;

   typedef struct packed {
      logic                          op;
      logic [ADDR_W-1:0]             index;
      logic signed [SAMPLE_BITS-1:0] value;
   } filter_req_type;

   typedef struct packed {
      logic signed [SAMPLE_BITS-1:0] sample;
      logic                          clipped;
   } filter_out_type;

   logic                          clock = 1'b0;
   logic                          reset = 1'b1;
   logic                          req_valid = 1'b0;
   logic                          req_stall;
   logic                          req_operation = OP_SAMPLE;
   logic [ADDR_W-1:0]             req_coef_index = '0;
   logic signed [SAMPLE_BITS-1:0] req_value = '0;
   logic                          rsp_valid;
   logic                          rsp_stall = 1'b0;
   logic signed [SAMPLE_BITS-1:0] rsp_filtered_sample;
   logic                          rsp_clipped;
   logic                          csr_valid = 1'b0;
   logic                          csr_ready;
   logic [CSR_IDX_W-1:0]          csr_index = CSR_RATIO;
   logic [CSR_DATA_W-1:0]         csr_wdata = '0;

   // Requests waiting to be offered, and outputs the filter still owes.
   filter_req_type pending_reqs[$];
   filter_out_type expected_outputs[$];

   // Predicted filter state and register copies.
   logic signed [SAMPLE_BITS-1:0] ring_mem [MAX_TAPS];
   logic signed [SAMPLE_BITS-1:0] coef_mem [MAX_TAPS];
   int unsigned                   ring_wr_pos = 0;
   int unsigned                   phase_cnt = 0;
   logic [RATIO_W-1:0]            cfg_ratio = RATIO_RESET;
   logic [TAPS_W-1:0]             cfg_taps = TAPS_RESET;

   int   errors = 0;
   int   send_idle_pct = 20;
   int   recv_idle_pct = 20;
   logic pressure_arm = 1'b0;
   logic pressure_done = 1'b0;
   int   hold_left = 0;

   fir_decimator dut (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_stall           (req_stall),
      .req_operation       (req_operation),
      .req_coef_index      (req_coef_index),
      .req_value           (req_value),
      .rsp_valid           (rsp_valid),
      .rsp_stall           (rsp_stall),
      .rsp_filtered_sample (rsp_filtered_sample),
      .rsp_clipped         (rsp_clipped),
      .csr_valid           (csr_valid),
      .csr_ready           (csr_ready),
      .csr_index           (csr_index),
      .csr_wdata           (csr_wdata)
   );

   initial begin
      forever #6 clock = ~clock;
   end

   // Out-of-range register values act as the nearest legal setting.
   function automatic int unsigned taps_in_use();
      if (cfg_taps == '0) return 1;
      if (cfg_taps > TAPS_W'(MAX_TAPS)) return MAX_TAPS;
      return cfg_taps;
   endfunction

   function automatic int unsigned ratio_in_use();
      if (cfg_ratio == '0) return 1;
      if (cfg_ratio > RATIO_W'(RATIO_MAX)) return RATIO_MAX;
      return cfg_ratio;
   endfunction

   // Applies one accepted request to the predicted state and queues the
   // decimated output it completes, if any.
   function automatic void advance_filter(input filter_req_type r);
      int unsigned    taps, rat, pos, idx, j;
      longint         acc, q;
      filter_out_type res;
      taps = taps_in_use();
      rat  = ratio_in_use();
      if (r.op == OP_LOAD) begin
         coef_mem[r.index] = r.value;
         return;
      end
      // A write position left beyond a shrunken tap count restarts at zero.
      pos = (ring_wr_pos < taps) ? ring_wr_pos : 0;
      ring_mem[pos] = r.value;
      pos++;
      if (pos >= taps) pos = 0;
      ring_wr_pos = pos;
      phase_cnt++;
      if (phase_cnt < rat) return;
      phase_cnt = 0;
      // The oldest sample sits at the write position and meets coefficient zero.
      acc = 0;
      idx = pos;
      for (j = 0; j < taps; j++) begin
         acc += longint'(ring_mem[idx]) * longint'(coef_mem[j]);
         idx++;
         if (idx >= taps) idx = 0;
      end
      q = (acc + (longint'(1) <<< (COEF_FRAC - 1))) >>> COEF_FRAC;
      res.clipped = 1'b0;
      if (q > longint'(2 ** (SAMPLE_BITS - 1) - 1)) begin
         q = 2 ** (SAMPLE_BITS - 1) - 1;
         res.clipped = 1'b1;
      end else if (q < -longint'(2 ** (SAMPLE_BITS - 1))) begin
         q = -longint'(2 ** (SAMPLE_BITS - 1));
         res.clipped = 1'b1;
      end
      res.sample = SAMPLE_BITS'(q);
      expected_outputs.push_back(res);
   endfunction

   function automatic filter_req_type random_request(input int load_pct,
                                                     input int unsigned taps_now);
      filter_req_type r;
      r.op = ($urandom_range(0, 99) < load_pct) ? OP_LOAD : OP_SAMPLE;
      if ($urandom_range(0, 4) == 0)
         r.index = ADDR_W'($urandom);
      else
         r.index = ADDR_W'($urandom_range(0, taps_now - 1));
      case ($urandom_range(0, 11))
         0: r.value = 16'sh8000;
         1: r.value = 16'sh7FFF;
         2: r.value = 16'sh4000;
         3: r.value = 16'shFFFF;
         default: begin
            r.value = SAMPLE_BITS'($urandom);
            // Smaller coefficients keep many sums clear of saturation.
            if (r.op == OP_LOAD) r.value = r.value >>> $urandom_range(0, 6);
         end
      endcase
      return r;
   endfunction

   function automatic void push_req(input logic op, input logic [ADDR_W-1:0] idx,
                                    input logic signed [SAMPLE_BITS-1:0] val);
      filter_req_type r;
      r.op    = op;
      r.index = idx;
      r.value = val;
      pending_reqs.push_back(r);
   endfunction

   // Register write; the predictor copy changes at the accepting edge.
   task automatic write_reg(input logic [CSR_IDX_W-1:0] idx,
                            input logic [CSR_DATA_W-1:0] data);
      @(posedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      do @(posedge clock); while (!csr_ready);
      if (idx == CSR_RATIO)
         cfg_ratio = data[RATIO_W-1:0];
      else
         cfg_taps = data;
      csr_valid <= 1'b0;
   endtask

   // Waits until every request is taken and every output has arrived, then
   // lets the filter settle for the given number of cycles.
   task automatic wait_drained(input int settle);
      do @(posedge clock);
      while (pending_reqs.size() != 0 || req_valid || expected_outputs.size() != 0);
      repeat (settle) @(posedge clock);
   endtask

   // Request driver: holds a stalled request, otherwise offers the next one
   // unless this cycle is an idle one.
   always @(posedge clock) begin : drive_requests
      logic           offer;
      filter_req_type nxt;
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         offer = req_valid;
         if (req_valid && !req_stall) begin
            nxt.op    = req_operation;
            nxt.index = req_coef_index;
            nxt.value = req_value;
            advance_filter(nxt);
            offer = 1'b0;
         end
         if (!offer && pending_reqs.size() != 0 &&
             $urandom_range(0, 99) >= send_idle_pct) begin
            nxt = pending_reqs.pop_front();
            req_operation  <= nxt.op;
            req_coef_index <= nxt.index;
            req_value      <= nxt.value;
            offer = 1'b1;
         end
         req_valid <= offer;
      end
   end

   // Output back-pressure: random stalls, plus one long hold-off when armed.
   always @(posedge clock) begin : drive_rsp_stall
      if (reset) begin
         rsp_stall <= 1'b0;
      end else if (hold_left != 0) begin
         hold_left--;
         rsp_stall <= 1'b1;
      end else if (pressure_arm && !pressure_done) begin
         hold_left = 400;
         pressure_done = 1'b1;
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= ($urandom_range(0, 99) < recv_idle_pct);
      end
   end

   // Output monitor: compares each accepted output with the oldest prediction.
   always @(posedge clock) begin : check_outputs
      filter_out_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_outputs.size() == 0) begin
            $error("filtered_sample: unexpected output %0d", rsp_filtered_sample);
            errors++;
         end else begin
            want = expected_outputs.pop_front();
            if (rsp_filtered_sample !== want.sample) begin
               $error("filtered_sample: expected %0d, actual %0d",
                      want.sample, rsp_filtered_sample);
               errors++;
            end
            if (rsp_clipped !== want.clipped) begin
               $error("clipped: expected %0d, actual %0d", want.clipped, rsp_clipped);
               errors++;
            end
         end
      end
   end

   initial begin : stimulus
      int unsigned rdata, tdata, taps_now;
      int          p;
      foreach (ring_mem[i]) begin
         ring_mem[i] = '0;
         coef_mem[i] = '0;
      end
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      // The stores are cleared after reset; requests are refused meanwhile.
      repeat (4) @(posedge clock);
      while (req_stall) @(posedge clock);

      // Reset settings: coefficient store extremes and sample extremes.
      push_req(OP_LOAD, ADDR_W'(0), 16'sh7FFF);
      push_req(OP_LOAD, ADDR_W'(564), 16'sh8000);
      push_req(OP_LOAD, ADDR_W'(1023), 16'shFFFF);
      push_req(OP_SAMPLE, ADDR_W'(1023), 16'sh7FFF);
      push_req(OP_SAMPLE, ADDR_W'(0), 16'sh8000);
      push_req(OP_SAMPLE, ADDR_W'(0), 16'sh0000);
      push_req(OP_SAMPLE, ADDR_W'(0), 16'shFFFF);
      push_req(OP_SAMPLE, ADDR_W'(0), 16'sh0001);
      push_req(OP_SAMPLE, ADDR_W'(0), 16'sh3039);
      push_req(OP_SAMPLE, ADDR_W'(0), 16'shFFFE);
      push_req(OP_SAMPLE, ADDR_W'(0), 16'sh7FFF);
      push_req(OP_SAMPLE, ADDR_W'(0), 16'sh8000);
      push_req(OP_SAMPLE, ADDR_W'(0), 16'sh7FFF);
      push_req(OP_SAMPLE, ADDR_W'(0), 16'sh4000);
      push_req(OP_SAMPLE, ADDR_W'(0), 16'shC000);
      push_req(OP_SAMPLE, ADDR_W'(0), 16'sh1234);
      wait_drained(40);

      // Two taps, one output per sample: the phase left over exceeds the new
      // ratio, the write position lies beyond the taps, and sums clip at both limits.
      write_reg(CSR_RATIO, CSR_DATA_W'(1));
      write_reg(CSR_TAPS, CSR_DATA_W'(2));
      push_req(OP_LOAD, ADDR_W'(0), 16'sh8000);
      push_req(OP_LOAD, ADDR_W'(1), 16'sh8000);
      push_req(OP_SAMPLE, ADDR_W'(0), 16'sh8000);
      push_req(OP_SAMPLE, ADDR_W'(0), 16'sh8000);
      push_req(OP_SAMPLE, ADDR_W'(0), 16'sh7FFF);
      push_req(OP_SAMPLE, ADDR_W'(0), 16'sh7FFF);
      wait_drained(40);

      // Zero in both registers acts as one.
      write_reg(CSR_RATIO, CSR_DATA_W'(0));
      write_reg(CSR_TAPS, CSR_DATA_W'(0));
      push_req(OP_SAMPLE, ADDR_W'(0), 16'sh8000);
      push_req(OP_SAMPLE, ADDR_W'(0), 16'sh0005);
      wait_drained(40);

      // Random phases, each with its own settings.
      for (p = 0; p < 10; p++) begin
         case (p)
            0: begin
               rdata = {6'($urandom), 5'd16};
               tdata = MAX_TAPS;
            end
            1: begin
               rdata = 11'h7FF;
               tdata = 11'h7FF;
            end
            2: begin
               rdata = 1;
               tdata = 3;
            end
            3: rdata = $urandom_range(1, 4);
            default: begin
               if ($urandom_range(0, 2) == 0)
                  rdata = $urandom_range(0, 2047);
               else
                  rdata = $urandom_range(1, 16);
            end
         endcase
         write_reg(CSR_RATIO, CSR_DATA_W'(rdata));
         if (p == 3 || (p > 3 && $urandom_range(0, 9) < 7))
            tdata = ratio_in_use() * $urandom_range(1, 3);
         else if (p > 3)
            tdata = $urandom_range(1, 64);
         write_reg(CSR_TAPS, CSR_DATA_W'(tdata));
         taps_now = taps_in_use();

         send_idle_pct <= (p == 2 || p == 3) ? 0 : 20;
         recv_idle_pct <= (p == 3) ? 0 : 20;
         pressure_arm  <= (p == 2);

         // Coefficients first, then a mixed stream of samples and loads.
         repeat ($urandom_range(2, 8))
            pending_reqs.push_back(random_request(100, taps_now));
         repeat (32)
            pending_reqs.push_back(random_request(20, taps_now));
         wait_drained(40);
      end

      send_idle_pct <= 20;
      recv_idle_pct <= 20;
      wait_drained(1100);
      if (errors == 0 && expected_outputs.size() == 0)
         $display("SUCCESS");
      else
         $display("FAILURE");
      $finish;
   end

   // Overall time limit.
   initial begin
      #30ms;
      $display("FAILURE");
      $finish;
   end

endmodule
